>>> sv/openpgp_packet_body_parser_unit_macros.svh
// Assertion macros for the OpenPGP packet body parser checker.
// No dependencies; included by the checker file.
`ifndef OPENPGP_PACKET_BODY_PARSER_UNIT_MACROS_SVH
`define OPENPGP_PACKET_BODY_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define OPGP_AST_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("opgp check failed");

// Next-cycle implication, also checked across reset.
`define OPGP_AST_NXT(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("opgp check failed");

`endif

>>> sv/opgp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the OpenPGP packet body parser.
// No dependencies.
package opgp_pkg;

    localparam int QDEPTH_DEF = 4;
    localparam int MAX_TOK    = 6;

    localparam logic [4:0] TK_PKT_START  = 5'd0;
    localparam logic [4:0] TK_HDR_BYTE   = 5'd1;
    localparam logic [4:0] TK_MPI_START  = 5'd2;
    localparam logic [4:0] TK_MPI_BODY   = 5'd3;
    localparam logic [4:0] TK_MPI_END    = 5'd4;
    localparam logic [4:0] TK_HASH_START = 5'd5;
    localparam logic [4:0] TK_HASH_END   = 5'd6;
    localparam logic [4:0] TK_UNH_START  = 5'd7;
    localparam logic [4:0] TK_UNH_END    = 5'd8;
    localparam logic [4:0] TK_SUB_START  = 5'd9;
    localparam logic [4:0] TK_SUB_BODY   = 5'd10;
    localparam logic [4:0] TK_SUB_END    = 5'd11;
    localparam logic [4:0] TK_LEFT16     = 5'd12;
    localparam logic [4:0] TK_OPS_DONE   = 5'd13;
    localparam logic [4:0] TK_COMP_DONE  = 5'd14;
    localparam logic [4:0] TK_SEIPD_DONE = 5'd15;
    localparam logic [4:0] TK_DATA       = 5'd16;
    localparam logic [4:0] TK_END        = 5'd17;
    localparam logic [4:0] TK_ERROR      = 5'd18;

    localparam logic [2:0] ER_NONE     = 3'd0;
    localparam logic [2:0] ER_VERSION  = 3'd1;
    localparam logic [2:0] ER_HASHLEN  = 3'd2;
    localparam logic [2:0] ER_OVERRUN  = 3'd3;
    localparam logic [2:0] ER_TWICE    = 3'd4;

    localparam logic [5:0] TAG_PKESK   = 6'd1;
    localparam logic [5:0] TAG_SIG     = 6'd2;
    localparam logic [5:0] TAG_OPS     = 6'd4;
    localparam logic [5:0] TAG_COMP    = 6'd8;
    localparam logic [5:0] TAG_MARKER  = 6'd10;
    localparam logic [5:0] TAG_SEIPD   = 6'd18;
    localparam logic [5:0] TAG_RESET   = TAG_SIG;

    typedef enum logic [3:0] {
        PH_HDR, PH_MPI_LEN, PH_MPI_BODY, PH_HLIST, PH_HSUB,
        PH_USIZE, PH_ULIST, PH_USUB, PH_LEFT16, PH_DATA
    } t_phase;

    // Tokens of one input beat. Slot 0 takes value v0, later packet start or done slots v1.
    typedef struct packed {
        logic [MAX_TOK-1:0][4:0] tok;
        logic [2:0]              cnt;
        logic [7:0]              data;
        logic [31:0]             v0;
        logic [31:0]             v1;
        logic [6:0]              styp;
        logic                    crit;
        logic [2:0]              ec;
    } t_bundle;

    function automatic logic tok_has_data(input logic [4:0] t);
        return t == TK_HDR_BYTE || t == TK_MPI_BODY || t == TK_SUB_BODY ||
               t == TK_LEFT16 || t == TK_DATA;
    endfunction

endpackage

>>> sv/opgp_front.sv
`timescale 1ns / 1ps
// Front end: parse state and classification of each body byte into a token bundle.
// Depends on opgp_pkg.
module opgp_front import opgp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    output t_bundle    o_bundle
);
    logic [5:0]  r_tag;
    t_phase      r_ph, n_ph;
    logic [4:0]  r_hc, n_hc;
    logic [7:0]  r_hs [6];
    logic [7:0]  n_hs [6];
    logic [15:0] r_lr, n_lr;
    logic [31:0] r_ir, n_ir;
    logic        r_done, n_done;
    logic [2:0]  r_err, n_err;

    t_bundle     bun;
    logic [2:0]  nc;
    logic        failed;
    logic [7:0]  b;
    logic [2:0]  need;
    logic [31:0] size, body;
    logic [32:0] used;
    logic [7:0]  typ;
    logic [15:0] nbits;

    always_comb begin
        n_ph = r_ph; n_hc = r_hc; n_hs = r_hs; n_lr = r_lr; n_ir = r_ir;
        n_done = r_done; n_err = r_err;
        bun = '0; nc = '0; failed = 1'b0; b = i_data_byte;
        need = 3'd2; size = '0; body = '0; used = '0; typ = '0; nbits = '0;
        bun.data = b;
        if (r_err != ER_NONE) begin
            bun.tok[nc] = TK_ERROR; nc = nc + 3'd1; bun.ec = r_err;
        end else if (i_func) begin
            if (r_done) begin
                n_err = ER_TWICE; bun.ec = ER_TWICE;
                bun.tok[nc] = TK_ERROR; nc = nc + 3'd1;
            end else begin
                n_done = 1'b1;
                bun.tok[nc] = TK_END; nc = nc + 3'd1;
            end
        end else begin
            // header echo: each header byte of a known, non-marker tag gets a hdr_byte token first
            if (n_ph == PH_HDR && (r_tag == TAG_PKESK || r_tag == TAG_SIG ||
                    r_tag == TAG_OPS || r_tag == TAG_COMP || r_tag == TAG_SEIPD)) begin
                bun.tok[nc] = TK_HDR_BYTE; nc = nc + 3'd1; bun.v0 = 32'(r_hc);
            end
            // byte collection into the small header store
            if ((n_ph == PH_HDR && r_tag != TAG_MARKER) || n_ph == PH_MPI_LEN ||
                    n_ph == PH_HLIST || n_ph == PH_ULIST || n_ph == PH_USIZE) begin
                if ((r_tag == TAG_PKESK || r_tag == TAG_SIG || r_tag == TAG_OPS ||
                        r_tag == TAG_COMP || r_tag == TAG_SEIPD) &&
                        !(n_ph == PH_DATA)) begin
                    if (r_hc < 5'd6) n_hs[r_hc[2:0]] = b;
                    n_hc = r_hc + 5'd1;
                end
            end
            unique case (r_tag)
                TAG_PKESK: begin
                    if (r_ph == PH_HDR) begin
                        if (n_hc == 5'd10) begin
                            if (n_hs[0] != 8'd3) begin
                                failed = 1'b1;
                            end else begin
                                bun.tok[nc] = TK_PKT_START; nc = nc + 3'd1;
                                bun.v1 = 32'(n_hs[0]);
                                n_hc = '0; n_ph = PH_MPI_LEN;
                            end
                            if (failed) begin
                                n_err = ER_VERSION; bun.ec = ER_VERSION;
                                bun.tok[nc] = TK_ERROR; nc = nc + 3'd1;
                            end
                        end
                    end else if (r_ph == PH_MPI_BODY) begin
                        bun.tok[nc] = TK_MPI_BODY; nc = nc + 3'd1;
                        n_ir = r_ir - 32'd1;
                    end else if (n_hc >= 5'd2) begin
                        nbits = {n_hs[0], n_hs[1]};
                        n_ir = 32'((17'(nbits) + 17'd7) >> 3);
                        bun.tok[nc] = TK_MPI_START; nc = nc + 3'd1;
                        bun.v0 = 32'(nbits);
                        n_hc = '0; n_ph = PH_MPI_BODY;
                    end
                end
                TAG_SIG: begin
                    unique case (r_ph)
                        PH_HDR: begin
                            if (n_hc == 5'd1 && (b < 8'd2 || b > 8'd4)) begin
                                failed = 1'b1; n_err = ER_VERSION; bun.ec = ER_VERSION;
                            end else if (n_hs[0] < 8'd4 && n_hc == 5'd19) begin
                                if (n_hs[1] != 8'd5) begin
                                    failed = 1'b1; n_err = ER_HASHLEN; bun.ec = ER_HASHLEN;
                                end else begin
                                    bun.tok[nc] = TK_PKT_START; nc = nc + 3'd1;
                                    bun.v1 = 32'(n_hs[0]);
                                    n_hc = '0; n_ph = PH_MPI_LEN;
                                end
                            end else if (n_hs[0] == 8'd4 && n_hc == 5'd6) begin
                                bun.tok[nc] = TK_PKT_START; nc = nc + 3'd1;
                                bun.v1 = 32'd4;
                                n_lr = {n_hs[4], n_hs[5]};
                                bun.tok[nc] = TK_HASH_START; nc = nc + 3'd1;
                                n_hc = '0; n_ph = PH_HLIST;
                            end
                            if (failed) begin
                                bun.tok[nc] = TK_ERROR; nc = nc + 3'd1;
                            end
                        end
                        PH_HLIST, PH_ULIST: begin
                            need = (n_hs[0] < 8'd192) ? 3'd2 :
                                   ((n_hs[0] < 8'd255) ? 3'd3 : 3'd6);
                            if (n_hc >= 5'(need)) begin
                                priority case (need)
                                    3'd2: size = 32'(n_hs[0]);
                                    3'd3: size = 32'({6'(n_hs[0] - 8'd192), n_hs[1]})
                                                 + 32'd192;
                                    default: size = {n_hs[1], n_hs[2], n_hs[3], n_hs[4]};
                                endcase
                                typ  = n_hs[need - 3'd1];
                                body = (size != '0) ? size - 32'd1 : '0;
                                used = 33'(need) + 33'(body);
                                if (used > 33'(r_lr)) begin
                                    failed = 1'b1; n_err = ER_OVERRUN; bun.ec = ER_OVERRUN;
                                    bun.tok[nc] = TK_ERROR; nc = nc + 3'd1;
                                end else begin
                                    n_lr = r_lr - used[15:0];
                                    n_ir = body;
                                    bun.tok[nc] = TK_SUB_START; nc = nc + 3'd1;
                                    bun.v0 = body; bun.styp = typ[6:0]; bun.crit = typ[7];
                                    n_hc = '0;
                                    n_ph = (r_ph == PH_HLIST) ? PH_HSUB : PH_USUB;
                                end
                            end
                        end
                        PH_HSUB, PH_USUB: begin
                            bun.tok[nc] = TK_SUB_BODY; nc = nc + 3'd1;
                            n_ir = r_ir - 32'd1;
                        end
                        PH_USIZE: begin
                            if (n_hc >= 5'd2) begin
                                n_lr = {n_hs[0], n_hs[1]};
                                bun.tok[nc] = TK_UNH_START; nc = nc + 3'd1;
                                n_hc = '0; n_ph = PH_ULIST;
                            end
                        end
                        PH_LEFT16: begin
                            bun.tok[nc] = TK_LEFT16; nc = nc + 3'd1;
                            bun.v0 = 32'(r_hc[0]);
                            n_hc = r_hc + 5'd1;
                            if (n_hc >= 5'd2) begin
                                n_hc = '0; n_ph = PH_MPI_LEN;
                            end
                        end
                        PH_MPI_BODY: begin
                            bun.tok[nc] = TK_MPI_BODY; nc = nc + 3'd1;
                            n_ir = r_ir - 32'd1;
                        end
                        PH_MPI_LEN: begin
                            if (n_hc >= 5'd2) begin
                                nbits = {n_hs[0], n_hs[1]};
                                n_ir = 32'((17'(nbits) + 17'd7) >> 3);
                                bun.tok[nc] = TK_MPI_START; nc = nc + 3'd1;
                                bun.v0 = 32'(nbits);
                                n_hc = '0; n_ph = PH_MPI_BODY;
                            end
                        end
                        default: begin
                            bun.tok[nc] = TK_DATA; nc = nc + 3'd1;
                        end
                    endcase
                end
                TAG_OPS: begin
                    if (r_ph == PH_HDR) begin
                        if (n_hc == 5'd1 && b != 8'd3) begin
                            failed = 1'b1; n_err = ER_VERSION; bun.ec = ER_VERSION;
                            bun.tok[nc] = TK_ERROR; nc = nc + 3'd1;
                        end else if (n_hc == 5'd13) begin
                            bun.tok[nc] = TK_OPS_DONE; nc = nc + 3'd1;
                            bun.v1 = 32'(n_hs[0]);
                            n_hc = '0; n_ph = PH_DATA;
                        end
                    end else begin
                        bun.tok[nc] = TK_DATA; nc = nc + 3'd1;
                    end
                end
                TAG_COMP, TAG_SEIPD: begin
                    if (r_ph == PH_HDR) begin
                        bun.tok[nc] = (r_tag == TAG_COMP) ? TK_COMP_DONE : TK_SEIPD_DONE;
                        nc = nc + 3'd1;
                        bun.v1 = 32'(b);
                        n_hc = '0; n_ph = PH_DATA;
                    end else begin
                        bun.tok[nc] = TK_DATA; nc = nc + 3'd1;
                    end
                end
                TAG_MARKER: ;
                default: begin
                    bun.tok[nc] = TK_DATA; nc = nc + 3'd1;
                end
            endcase
            // close empty items and drained lists; at most two in a row
            if (!failed) begin
                for (int k = 0; k < 2; k++) begin
                    if (n_ph == PH_MPI_BODY && n_ir == '0) begin
                        bun.tok[nc] = TK_MPI_END; nc = nc + 3'd1; n_ph = PH_MPI_LEN;
                    end else if (n_ph == PH_HSUB && n_ir == '0) begin
                        bun.tok[nc] = TK_SUB_END; nc = nc + 3'd1; n_ph = PH_HLIST;
                    end else if (n_ph == PH_USUB && n_ir == '0) begin
                        bun.tok[nc] = TK_SUB_END; nc = nc + 3'd1; n_ph = PH_ULIST;
                    end else if (n_ph == PH_HLIST && n_lr == '0) begin
                        bun.tok[nc] = TK_HASH_END; nc = nc + 3'd1; n_ph = PH_USIZE;
                    end else if (n_ph == PH_ULIST && n_lr == '0) begin
                        bun.tok[nc] = TK_UNH_END; nc = nc + 3'd1; n_ph = PH_LEFT16;
                    end
                end
            end
        end
        bun.cnt = nc;
    end

    assign o_bundle = bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_tag  <= i_rst_n ? i_cfg_data : TAG_RESET;
            r_ph   <= PH_HDR;
            r_hc   <= '0;
            r_lr   <= '0;
            r_ir   <= '0;
            r_done <= 1'b0;
            r_err  <= ER_NONE;
        end else if (i_accept) begin
            r_ph   <= n_ph;
            r_hc   <= n_hc;
            r_lr   <= n_lr;
            r_ir   <= n_ir;
            r_done <= n_done;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_hs <= n_hs;
    end
endmodule

>>> sv/opgp_queue.sv
`timescale 1ns / 1ps
// Short bundle queue between the parser front and the token back end.
// Depends on opgp_pkg.
module opgp_queue import opgp_pkg::*; #(
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_wdata,
    input  logic    i_rd,
    output t_bundle o_rdata,
    output logic    o_full,
    output logic    o_nempty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_bundle            r_mem [DEPTH];
    logic [AW-1:0]      r_wp, r_rp;
    logic [AW:0]        r_cnt;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + AW'(1);
    endfunction

    assign o_full   = (r_cnt == (AW+1)'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_rdata  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= inc(r_wp);
            if (i_rd) r_rp <= inc(r_rp);
            r_cnt <= r_cnt + (AW+1)'(i_wr) - (AW+1)'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wdata;
    end
endmodule

>>> sv/opgp_back.sv
`timescale 1ns / 1ps
// Back end: holds one bundle and presents its tokens one beat at a time.
// Depends on opgp_pkg.
module opgp_back import opgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_nempty,
    input  t_bundle     i_q_data,
    output logic        o_q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [4:0]  o_token,
    output logic [7:0]  o_data_out,
    output logic [31:0] o_value,
    output logic [6:0]  o_subpacket_type,
    output logic        o_critical,
    output logic [2:0]  o_error_code,
    output logic        o_last
);
    t_bundle    r_bun;
    logic [2:0] r_slot;
    logic       r_valid;
    logic       at_last, free;
    logic [4:0] t;
    logic       v1_tok;

    assign at_last = (r_slot == r_bun.cnt - 3'd1);
    assign free    = !r_valid || (pop && at_last);
    assign o_q_rd  = free && i_q_nempty;
    assign empty   = !r_valid;

    assign t = r_bun.tok[r_slot];
    // v1 belongs to the packet start / header done token only
    assign v1_tok = (t == TK_PKT_START) || (t == TK_OPS_DONE) ||
                    (t == TK_COMP_DONE) || (t == TK_SEIPD_DONE);
    always_comb begin
        o_token          = t;
        o_data_out       = tok_has_data(t) ? r_bun.data : '0;
        o_value          = (r_slot == '0) ? r_bun.v0 : (v1_tok ? r_bun.v1 : '0);
        o_subpacket_type = (t == TK_SUB_START) ? r_bun.styp : '0;
        o_critical       = (t == TK_SUB_START) && r_bun.crit;
        o_error_code     = (t == TK_ERROR) ? r_bun.ec : ER_NONE;
        o_last           = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else if (free) begin
            r_valid <= i_q_nempty;
            r_slot  <= '0;
        end else if (pop) begin
            r_slot  <= r_slot + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) r_bun <= i_q_data;
    end
endmodule

>>> sv/openpgp_packet_body_parser_unit.sv
`timescale 1ns / 1ps
// OpenPGP packet body parser, top level: front parser, bundle queue, token back end.
// Depends on opgp_pkg, opgp_front, opgp_queue, opgp_back.
//
// Takes one packet body byte (or a finish marker) per beat, with the packet tag
// written in through the config port while idle (a write restarts parsing), and
// produces RFC 4880 parse tokens. Input side accepts one beat per clock as long
// as full is low; full rises only when QDEPTH beats' worth of tokens are queued.
// The front classifies each beat combinationally into a bundle of 0 to 6 tokens;
// the back end delivers one token per clock on pop, so sustained rate is one
// beat per cycle when beats produce one token each, and beats that yield several
// end markers are absorbed by the queue. An accepted beat is registered in the
// queue, then in the back end, before its first token. No clearing pass after reset.
module openpgp_packet_body_parser_unit import opgp_pkg::*; #(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_token,
    output logic [7:0]  o_data_out,
    output logic [31:0] o_value,
    output logic [6:0]  o_subpacket_type,
    output logic        o_critical,
    output logic [2:0]  o_error_code,
    output logic        o_last
);
    logic    accept;
    t_bundle fbun, qbun;
    logic    q_nempty, q_rd;

    // a pushed beat is taken whenever the queue has room
    assign accept = push && !full;

    opgp_front u_front (
        .i_clk, .i_rst_n, .i_accept(accept), .i_func, .i_data_byte,
        .i_cfg_we, .i_cfg_data, .o_bundle(fbun)
    );

    // beats with no tokens (marker tag, or bytes only collected as header) never enter the queue
    opgp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_wr(accept && fbun.cnt != '0), .i_wdata(fbun),
        .i_rd(q_rd), .o_rdata(qbun), .o_full(full), .o_nempty(q_nempty)
    );

    opgp_back u_back (
        .i_clk, .i_rst_n, .i_q_nempty(q_nempty), .i_q_data(qbun), .o_q_rd(q_rd),
        .pop, .empty, .o_token, .o_data_out, .o_value, .o_subpacket_type,
        .o_critical, .o_error_code, .o_last
    );
endmodule

>>> sv/opgp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the parser top level, bound in below.
// Depends on opgp_pkg and openpgp_packet_body_parser_unit_macros.svh.
`include "openpgp_packet_body_parser_unit_macros.svh"
module opgp_checker import opgp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic [4:0]  o_token,
    input logic [6:0]  o_subpacket_type,
    input logic        o_critical,
    input logic [2:0]  o_error_code
);
    `OPGP_AST_IMP(a_tok_range, i_clk, i_rst_n, !empty, o_token <= TK_ERROR)
    `OPGP_AST_IMP(a_ec_only_err, i_clk, i_rst_n, !empty && o_token != TK_ERROR, o_error_code == ER_NONE)
    `OPGP_AST_IMP(a_sub_only, i_clk, i_rst_n, !empty && o_token != TK_SUB_START, !o_critical && o_subpacket_type == '0)
    `OPGP_AST_NXT(a_rst_empty, i_clk, !i_rst_n, empty)
endmodule

bind openpgp_packet_body_parser_unit opgp_checker u_chk (
    .i_clk, .i_rst_n, .empty, .o_token, .o_subpacket_type, .o_critical, .o_error_code
);

>>> dv/opgp_token_checker.sv
`timescale 1ns / 1ps
// Token checker for the OpenPGP packet body parser: watches the input, config and
// result queues, predicts the token stream and compares it field by field.
// Depends on opgp_pkg for token, error, tag and phase codes.
module opgp_token_checker import opgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        empty,
    input  logic        pop,
    input  logic [4:0]  i_token,
    input  logic [7:0]  i_data_out,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_subpacket_type,
    input  logic        i_critical,
    input  logic [2:0]  i_error_code,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_tokens_due
);

    typedef struct packed {
        logic [4:0]  tok;
        logic [7:0]  dat;
        logic [31:0] val;
        logic [6:0]  styp;
        logic        crit;
        logic [2:0]  ec;
        logic        lst;
    } t_token;

    t_token tokens_due[$];
    t_token beat_tokens[$];

    // parser state mirror
    logic [5:0]  tag;
    t_phase      ph;
    logic [4:0]  hcnt;
    logic [7:0]  hst [6];
    logic [31:0] list_rem;
    logic [31:0] item_rem;
    logic        done;
    logic [2:0]  err;

    assign o_tokens_due = tokens_due.size();

    function automatic void clear_parser();
        ph = PH_HDR;
        hcnt = '0;
        for (int i = 0; i < 6; i++) hst[i] = '0;
        list_rem = '0;
        item_rem = '0;
        done = 1'b0;
        err = ER_NONE;
    endfunction

    function automatic void put(logic [4:0] t, logic [7:0] d, logic [31:0] v,
                                logic [6:0] st, logic cr, logic [2:0] ec);
        t_token x;
        if (beat_tokens.size() >= 6) return;
        x = '{tok: t, dat: d, val: v, styp: st, crit: cr, ec: ec, lst: 1'b0};
        beat_tokens.push_back(x);
    endfunction

    function automatic void raise(logic [2:0] code);
        err = code;
        put(TK_ERROR, 0, 0, 0, 0, code);
    endfunction

    function automatic void store(logic [7:0] b);
        if (hcnt < 6) hst[hcnt] = b;
        hcnt = hcnt + 1'b1;
    endfunction

    function automatic void echo(logic [7:0] b);
        put(TK_HDR_BYTE, b, 32'(hcnt), 0, 0, 0);
        store(b);
    endfunction

    // close out every item/list that has run to zero
    function automatic void settle();
        forever begin
            if (ph == PH_MPI_BODY && item_rem == 0) begin
                put(TK_MPI_END, 0, 0, 0, 0, 0);
                ph = PH_MPI_LEN;
            end else if (ph == PH_HSUB && item_rem == 0) begin
                put(TK_SUB_END, 0, 0, 0, 0, 0);
                ph = PH_HLIST;
            end else if (ph == PH_USUB && item_rem == 0) begin
                put(TK_SUB_END, 0, 0, 0, 0, 0);
                ph = PH_ULIST;
            end else if (ph == PH_HLIST && list_rem == 0) begin
                put(TK_HASH_END, 0, 0, 0, 0, 0);
                ph = PH_USIZE;
            end else if (ph == PH_ULIST && list_rem == 0) begin
                put(TK_UNH_END, 0, 0, 0, 0, 0);
                ph = PH_LEFT16;
            end else begin
                return;
            end
        end
    endfunction

    function automatic void mpi_byte(logic [7:0] b);
        logic [31:0] nbits;
        if (ph == PH_MPI_BODY) begin
            put(TK_MPI_BODY, b, 0, 0, 0, 0);
            item_rem = item_rem - 1;
            settle();
            return;
        end
        ph = PH_MPI_LEN;
        store(b);
        if (hcnt >= 2) begin
            nbits = {16'd0, hst[0], hst[1]};
            item_rem = (nbits + 7) / 8;
            put(TK_MPI_START, 0, nbits, 0, 0, 0);
            hcnt = '0;
            ph = PH_MPI_BODY;
            settle();
        end
    endfunction

    function automatic void sub_header(logic [7:0] b, t_phase body_ph);
        logic [7:0]  b0, typ;
        int          need;
        logic [31:0] size, body;
        logic [63:0] used;
        store(b);
        b0 = hst[0];
        need = (b0 < 192) ? 2 : ((b0 < 255) ? 3 : 6);
        if (hcnt < need) return;
        if (need == 2) size = 32'(b0);
        else if (need == 3) size = ((32'(b0) - 192) << 8) + 32'(hst[1]) + 192;
        else size = {hst[1], hst[2], hst[3], hst[4]};
        typ = hst[need-1];
        body = (size != 0) ? size - 1 : 0;
        used = 64'(need) + 64'(body);
        if (used > 64'(list_rem)) begin
            raise(ER_OVERRUN);
            return;
        end
        list_rem = list_rem - used[31:0];
        item_rem = body;
        put(TK_SUB_START, 0, body, typ[6:0], typ[7], 0);
        hcnt = '0;
        ph = body_ph;
        settle();
    endfunction

    function automatic void sig_byte(logic [7:0] b);
        case (ph)
            PH_HDR: begin
                echo(b);
                if (hcnt == 1 && (b < 2 || b > 4)) begin
                    raise(ER_VERSION);
                    return;
                end
                if (hst[0] < 4 && hcnt == 19) begin
                    if (hst[1] != 5) begin
                        raise(ER_HASHLEN);
                        return;
                    end
                    put(TK_PKT_START, 0, 32'(hst[0]), 0, 0, 0);
                    hcnt = '0;
                    ph = PH_MPI_LEN;
                end else if (hst[0] == 4 && hcnt == 6) begin
                    put(TK_PKT_START, 0, 4, 0, 0, 0);
                    list_rem = {16'd0, hst[4], hst[5]};
                    put(TK_HASH_START, 0, 0, 0, 0, 0);
                    hcnt = '0;
                    ph = PH_HLIST;
                    settle();
                end
            end
            PH_HLIST: sub_header(b, PH_HSUB);
            PH_ULIST: sub_header(b, PH_USUB);
            PH_HSUB, PH_USUB: begin
                put(TK_SUB_BODY, b, 0, 0, 0, 0);
                item_rem = item_rem - 1;
                settle();
            end
            PH_USIZE: begin
                store(b);
                if (hcnt >= 2) begin
                    list_rem = {16'd0, hst[0], hst[1]};
                    put(TK_UNH_START, 0, 0, 0, 0, 0);
                    hcnt = '0;
                    ph = PH_ULIST;
                    settle();
                end
            end
            PH_LEFT16: begin
                put(TK_LEFT16, b, 32'(hcnt[0]), 0, 0, 0);
                hcnt = hcnt + 1'b1;
                if (hcnt >= 2) begin
                    hcnt = '0;
                    ph = PH_MPI_LEN;
                end
            end
            PH_MPI_LEN, PH_MPI_BODY: mpi_byte(b);
            default: put(TK_DATA, b, 0, 0, 0, 0);
        endcase
    endfunction

    function automatic void body_byte(logic [7:0] b);
        case (tag)
            TAG_PKESK: begin
                if (ph == PH_HDR) begin
                    echo(b);
                    if (hcnt == 10) begin
                        if (hst[0] != 3) begin
                            raise(ER_VERSION);
                            return;
                        end
                        put(TK_PKT_START, 0, 32'(hst[0]), 0, 0, 0);
                        hcnt = '0;
                        ph = PH_MPI_LEN;
                    end
                end else begin
                    mpi_byte(b);
                end
            end
            TAG_SIG: sig_byte(b);
            TAG_OPS: begin
                if (ph == PH_HDR) begin
                    echo(b);
                    if (hcnt == 1 && b != 3) begin
                        raise(ER_VERSION);
                        return;
                    end
                    if (hcnt == 13) begin
                        put(TK_OPS_DONE, 0, 32'(hst[0]), 0, 0, 0);
                        hcnt = '0;
                        ph = PH_DATA;
                    end
                end else begin
                    put(TK_DATA, b, 0, 0, 0, 0);
                end
            end
            TAG_COMP, TAG_SEIPD: begin
                if (ph == PH_HDR) begin
                    echo(b);
                    put(tag == TAG_COMP ? TK_COMP_DONE : TK_SEIPD_DONE, 0, 32'(b), 0, 0, 0);
                    hcnt = '0;
                    ph = PH_DATA;
                end else begin
                    put(TK_DATA, b, 0, 0, 0, 0);
                end
            end
            TAG_MARKER: ;
            default: put(TK_DATA, b, 0, 0, 0, 0);
        endcase
    endfunction

    function automatic void predict_beat(logic func, logic [7:0] b);
        t_token x;
        beat_tokens.delete();
        if (err != ER_NONE) begin
            put(TK_ERROR, 0, 0, 0, 0, err);
        end else if (func) begin
            if (done) raise(ER_TWICE);
            else begin
                done = 1'b1;
                put(TK_END, 0, 0, 0, 0, 0);
            end
        end else begin
            body_byte(b);
        end
        foreach (beat_tokens[i]) begin
            x = beat_tokens[i];
            x.lst = (i == beat_tokens.size() - 1);
            tokens_due.push_back(x);
        end
    endfunction

    task automatic compare_token();
        t_token e;
        if (tokens_due.size() == 0) begin
            $error("unexpected token %0d, nothing outstanding", i_token);
            o_fail_count++;
            return;
        end
        e = tokens_due.pop_front();
        if (i_token !== e.tok) begin
            $error("token: exp %0d got %0d", e.tok, i_token); o_fail_count++;
        end
        if (i_data_out !== e.dat) begin
            $error("data_out: exp %0d got %0d", e.dat, i_data_out); o_fail_count++;
        end
        if (i_value !== e.val) begin
            $error("value: exp %0d got %0d", e.val, i_value); o_fail_count++;
        end
        if (i_subpacket_type !== e.styp) begin
            $error("subpacket_type: exp %0d got %0d", e.styp, i_subpacket_type);
            o_fail_count++;
        end
        if (i_critical !== e.crit) begin
            $error("critical: exp %0d got %0d", e.crit, i_critical); o_fail_count++;
        end
        if (i_error_code !== e.ec) begin
            $error("error_code: exp %0d got %0d", e.ec, i_error_code); o_fail_count++;
        end
        if (i_last !== e.lst) begin
            $error("last: exp %0d got %0d", e.lst, i_last); o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    // results are checked before the same edge's input beat is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tag = TAG_RESET;
            clear_parser();
            tokens_due.delete();
        end else begin
            if (i_cfg_we) begin
                tag = i_cfg_data;
                clear_parser();
            end
            if (pop && !empty) compare_token();
            if (push && !full) predict_beat(i_func, i_data_byte);
        end
    end

endmodule

>>> dv/tb_openpgp_packet_body_parser_unit.sv
`timescale 1ns / 1ps
// Testbench top for the OpenPGP packet body parser: clock, reset, stimulus and verdict.
// Depends on opgp_pkg, the parser top level and opgp_token_checker.
module tb_openpgp_packet_body_parser_unit;
    import opgp_pkg::*;

    localparam int ITEM_TARGET = 320;     // directed plus random beats
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_func;
    logic [7:0]  i_data_byte;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_data;
    logic        empty;
    logic        pop;
    logic [4:0]  o_token;
    logic [7:0]  o_data_out;
    logic [31:0] o_value;
    logic [6:0]  o_subpacket_type;
    logic        o_critical;
    logic [2:0]  o_error_code;
    logic        o_last;

    int fail_count;
    int tokens_due;
    int items_sent;
    int pops_seen = 0;
    int cycles = 0;
    int idle_mode;              // 0 none, 1 sender, 2 receiver, 3 both
    logic [5:0] cur_tag;
    logic [7:0] pkt [$];         // bytes of the packet being built

    openpgp_packet_body_parser_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_func           (i_func),
        .i_data_byte      (i_data_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .empty            (empty),
        .pop              (pop),
        .o_token          (o_token),
        .o_data_out       (o_data_out),
        .o_value          (o_value),
        .o_subpacket_type (o_subpacket_type),
        .o_critical       (o_critical),
        .o_error_code     (o_error_code),
        .o_last           (o_last)
    );

    opgp_token_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_func           (i_func),
        .i_data_byte      (i_data_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .empty            (empty),
        .pop              (pop),
        .i_token          (o_token),
        .i_data_out       (o_data_out),
        .i_value          (o_value),
        .i_subpacket_type (o_subpacket_type),
        .i_critical       (o_critical),
        .i_error_code     (o_error_code),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_tokens_due     (tokens_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("openpgp_packet_body_parser_unit verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) if (pop && !empty) pops_seen <= pops_seen + 1;

    // Receiver: random stalls per idle mode, plus one long hold-off so the
    // token queue fills and full pushes back on the sender.
    initial begin
        bit held;
        held = 1'b0;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && pops_seen >= 60) begin
                held = 1'b1;
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (idle_mode == 2) pop = ($urandom_range(0, 99) >= 79);
            else if (idle_mode == 3) pop = ($urandom_range(0, 99) >= 38);
            else pop = 1'b1;
        end
    end

    // One input beat; entered and left just after a falling edge.
    task automatic send_beat(logic func, logic [7:0] b);
        if (idle_mode == 1)
            while ($urandom_range(0, 99) < 79) @(negedge i_clk);
        else if (idle_mode == 3)
            while ($urandom_range(0, 99) < 38) @(negedge i_clk);
        push = 1'b1;
        i_func = func;
        i_data_byte = b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        push = 1'b0;
        if (cur_tag != TAG_MARKER) items_sent++;
        // idle mode walks through its phases as the run advances
        idle_mode = (items_sent * 4) / ITEM_TARGET;
        if (idle_mode > 3) idle_mode = 3;
    endtask

    task automatic send_pkt(bit finish);
        foreach (pkt[i]) send_beat(1'b0, pkt[i]);
        if (finish) send_beat(1'b1, 8'($urandom_range(0, 255)));
        pkt.delete();
    endtask

    // Drain the token queue, then allow the pipeline to go quiet before a config write.
    task automatic write_tag(logic [5:0] t);
        while (tokens_due != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = t;
        cur_tag = t;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic void add_rand(int n);
        repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One subpacket with a random length form: body is size - 1.
    function automatic void add_sub(ref logic [7:0] q[$]);
        int form, size;
        form = $urandom_range(0, 9);
        if (form == 8) begin
            size = $urandom_range(192, 260);
            q.push_back(8'(192 + ((size - 192) >> 8)));
            q.push_back(8'(size - 192));
        end else if (form == 9) begin
            size = $urandom_range(0, 10);
            q.push_back(8'd255);
            q.push_back(8'd0); q.push_back(8'd0); q.push_back(8'd0);
            q.push_back(8'(size));
        end else begin
            size = (form == 7) ? $urandom_range(0, 191) : $urandom_range(0, 10);
            q.push_back(8'(size));
        end
        q.push_back(8'($urandom_range(0, 255)));    // type, bit 7 critical
        for (int i = 1; i < size; i++) q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_mpis();
        int n, bits;
        n = $urandom_range(1, 2);
        repeat (n) begin
            bits = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 48);
            pkt.push_back(8'(bits >> 8));
            pkt.push_back(8'(bits));
            add_rand((bits + 7) / 8);
        end
    endfunction

    // v4 signature; a tenth of them carry a wrong hashed list length
    task automatic gen_sig_v4();
        logic [7:0] hq [$], uq [$];
        int hlen;
        repeat ($urandom_range(0, 3)) add_sub(hq);
        repeat ($urandom_range(0, 3)) add_sub(uq);
        hlen = hq.size();
        if ($urandom_range(0, 9) == 0) hlen = $urandom_range(0, 40);
        pkt.push_back(8'd4);
        add_rand(3);
        pkt.push_back(8'(hlen >> 8));
        pkt.push_back(8'(hlen));
        foreach (hq[i]) pkt.push_back(hq[i]);
        pkt.push_back(8'(uq.size() >> 8));
        pkt.push_back(8'(uq.size()));
        foreach (uq[i]) pkt.push_back(uq[i]);
        add_rand(2);                               // left16
        add_mpis();
        write_tag(TAG_SIG);
        send_pkt($urandom_range(0, 9) != 0);
    endtask

    task automatic gen_sig_v3();
        pkt.push_back(8'($urandom_range(2, 3)));
        pkt.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'd5);
        add_rand(17);
        add_mpis();
        write_tag(TAG_SIG);
        send_pkt(1'b1);
    endtask

    task automatic gen_pkesk();
        pkt.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd3);
        add_rand(9);
        add_mpis();
        write_tag(TAG_PKESK);
        send_pkt(1'b1);
    endtask

    task automatic gen_ops();
        pkt.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd3);
        add_rand(12 + $urandom_range(0, 4));
        write_tag(TAG_OPS);
        send_pkt(1'b1);
    endtask

    task automatic gen_simple(logic [5:0] t);
        add_rand($urandom_range(1, 8));
        write_tag(t);
        send_pkt(1'b1);
        if ($urandom_range(0, 2) == 0) send_beat(1'b1, 8'd0);    // finish twice
    endtask

    // Broken signature: random bytes and finishes, parser runs into errors.
    task automatic gen_noise();
        write_tag(TAG_SIG);
        repeat ($urandom_range(2, 10))
            send_beat($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [5:0] other;
        int k;
        push = 1'b0;
        i_func = 1'b0;
        i_data_byte = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        idle_mode = 0;
        items_sent = 0;
        cur_tag = TAG_RESET;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset tag: v4 with one empty critical subpacket, empty
        // unhashed list, left16, zero-length MPI, finish, finish again, sticky.
        pkt = '{8'd4, 8'h00, 8'hFF, 8'h01, 8'd0, 8'd2,
                8'd0, 8'h80,
                8'd0, 8'd0,
                8'hFF, 8'h00,
                8'd0, 8'd0};
        send_pkt(1'b1);
        send_beat(1'b1, 8'd0);
        send_beat(1'b0, 8'hFF);
        // overrun: two-byte length form at its top, list of 3
        write_tag(TAG_SIG);
        pkt = '{8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 8'd254, 8'd255, 8'd1};
        send_pkt(1'b0);
        write_tag(6'd63);
        send_beat(1'b0, 8'hFF);
        write_tag(6'd0);
        send_beat(1'b0, 8'h00);
        write_tag(TAG_SIG);
        send_beat(1'b0, 8'h01);                    // bad version

        k = 0;
        while (items_sent < ITEM_TARGET) begin
            // the first round visits every kind in order
            case ((k < 10) ? k : $urandom_range(0, 12))
                0, 10, 11, 12: gen_sig_v4();
                1: gen_sig_v3();
                2: gen_pkesk();
                3: gen_ops();
                4: gen_simple(TAG_COMP);
                5: gen_simple(TAG_SEIPD);
                6: gen_simple(TAG_MARKER);
                7: begin
                    other = 6'($urandom_range(0, 63));
                    if (other inside {TAG_PKESK, TAG_SIG, TAG_OPS, TAG_COMP,
                                      TAG_MARKER, TAG_SEIPD})
                        other = 6'd63;
                    gen_simple(other);
                end
                8: gen_noise();
                default: gen_sig_v4();
            endcase
            k++;
        end

        while (tokens_due != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("openpgp_packet_body_parser_unit verification clean");
        else
            $display("openpgp_packet_body_parser_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/opgp_pkg.sv
sv/opgp_front.sv
sv/opgp_queue.sv
sv/opgp_back.sv
sv/openpgp_packet_body_parser_unit.sv
sv/opgp_checker.sv
dv/opgp_token_checker.sv
dv/tb_openpgp_packet_body_parser_unit.sv
